/* rtl/core/assert_macros.svh */
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define ASSERT_CLKD(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");

// Clocked assertion that is also checked during reset.
`define ASSERT_CLKD_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");

`endif

/* rtl/core/emfp_pkg.sv */
package emfp_pkg;

    // Frame geometry.
    localparam int unsigned FRAME_LEN = 24;
    localparam int unsigned SUM_FIRST = 2;
    localparam int unsigned SUM_LAST = 22;
    localparam int unsigned CHECK_POS = 23;
    localparam int unsigned STATUS_POS = 20;
    localparam int unsigned PULSE_HI_POS = 21;
    localparam int unsigned PULSE_LO_POS = 22;
    localparam logic [7:0] HEADER_BYTE = 8'h5A;

    // Width of the frame counters, which wrap.
    localparam int unsigned COUNTER_BITS = 32;

    localparam int unsigned POS_W = 5;
    localparam logic [POS_W-1:0] POS_IDLE = POS_W'(FRAME_LEN);

    typedef logic [7:0] t_byte;
    typedef logic [23:0] t_word24;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK = 2'd0,
        ST_BAD_HEADER = 2'd1,
        ST_BAD_SUM = 2'd2
    } t_status;

    // State that survives from one accepted frame to the next.
    typedef struct packed {
        t_word24 [2:0] param;
        t_word24 [2:0] data;
        logic [15:0] pulse;
        logic [COUNTER_BITS-1:0] wrap_cnt;
        logic [COUNTER_BITS-1:0] flag_cnt;
    } t_held;

endpackage

/* rtl/core/emfp_if.sv */
// Input channel: one frame byte per transfer.
interface emfp_in_if;
    logic valid;
    logic ready;
    logic [7:0] data_byte;
    logic frame_start;

    modport source (output valid, output data_byte, output frame_start, input ready);
    modport sink (input valid, input data_byte, input frame_start, output ready);
endinterface

// Output channel: one result per completed frame.
interface emfp_out_if;
    logic valid;
    logic ready;
    logic [1:0] status;
    logic [23:0] voltage_param;
    logic [23:0] voltage_value;
    logic [23:0] current_param;
    logic [23:0] current_value;
    logic [23:0] power_param;
    logic [23:0] power_value;
    logic [15:0] pulse_register;
    logic [31:0] pulse_wrap_count;
    logic [31:0] flagged_frame_count;

    modport source (
        output valid, output status,
        output voltage_param, output voltage_value,
        output current_param, output current_value,
        output power_param, output power_value,
        output pulse_register, output pulse_wrap_count, output flagged_frame_count,
        input ready
    );
    modport sink (
        input valid, input status,
        input voltage_param, input voltage_value,
        input current_param, input current_value,
        input power_param, input power_value,
        input pulse_register, input pulse_wrap_count, input flagged_frame_count,
        output ready
    );
endinterface

/* rtl/core/emfp_frame_eval.sv */
// Checks a completed frame and works out the held state that follows it.
module emfp_frame_eval
    import emfp_pkg::*;
(
    input  t_byte [FRAME_LEN-1:0] i_frame,
    input  t_byte                 i_check_byte,
    input  t_byte                 i_sum,
    input  t_held                 i_held,
    output t_status               o_status,
    output t_held                 o_held
);

    logic  bad_header;
    logic  bad_sum;
    t_byte status_byte;
    logic [15:0] pulse;

    assign bad_header = (i_frame[1] != HEADER_BYTE);
    assign bad_sum = (i_sum != i_check_byte);
    assign status_byte = i_frame[STATUS_POS];
    assign pulse = {i_frame[PULSE_HI_POS], i_frame[PULSE_LO_POS]};

    // A bad header is reported before a bad checksum; any error keeps the held state.
    always_comb begin
        o_held = i_held;
        priority if (bad_header) begin
            o_status = ST_BAD_HEADER;
        end else if (bad_sum) begin
            o_status = ST_BAD_SUM;
        end else begin
            o_status = ST_OK;
            for (int k = 0; k < 3; k++) begin
                o_held.param[k] = {i_frame[2 + 6*k], i_frame[3 + 6*k], i_frame[4 + 6*k]};
                if (status_byte[6 - k]) begin
                    o_held.data[k] = {i_frame[5 + 6*k], i_frame[6 + 6*k], i_frame[7 + 6*k]};
                end
            end
            if (status_byte[7]) begin
                o_held.flag_cnt = i_held.flag_cnt + COUNTER_BITS'(1);
            end
            if (i_held.pulse > pulse) begin
                o_held.wrap_cnt = i_held.wrap_cnt + COUNTER_BITS'(1);
            end
            o_held.pulse = pulse;
        end
    end

endmodule

/* rtl/core/energy_meter_frame_parser_core.sv */
// Energy meter frame parser. Frame bytes arrive one per transfer on i_in_ch; a byte
// with frame_start set is byte 0 and always restarts the parse, and bytes outside a
// frame are dropped. When byte 23 is processed the frame is checked (byte 1 must be
// 0x5A, the 8-bit sum of bytes 2 to 22 must equal byte 23) and one result leaves on
// o_out_ch with the status and the held register values after that frame. A byte is
// taken every cycle while the processing stage does not wait; each one passes an input
// register and a single processing stage, and the result is held in the output register. The
// processing stage waits only while the output register holds a result that has not been taken.
module energy_meter_frame_parser_core
    import emfp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    emfp_in_if.sink    i_in_ch,
    emfp_out_if.source o_out_ch
);

    // Input register.
    logic  r_in_valid;
    t_byte r_in_byte;
    logic  r_in_start;

    // Parse state.
    logic [POS_W-1:0] r_pos;
    t_byte            r_sum;
    t_byte [FRAME_LEN-1:0] r_frame;
    t_held            r_held;

    // Output register.
    logic    r_out_valid;
    t_status r_out_status;
    t_held   r_out_held;

    logic    advance;
    logic    in_ready;
    logic    finish;
    t_status n_status;
    t_held   n_held;

    // The stage moves on when the output register is free or being emptied.
    assign advance = !r_out_valid || o_out_ch.ready;
    assign in_ready = !r_in_valid || advance;
    assign i_in_ch.ready = in_ready;

    assign finish = r_in_valid && advance && !r_in_start && (r_pos == POS_W'(CHECK_POS));

    // Input register load.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_in_ch.valid;
        end
        if (in_ready && i_in_ch.valid) begin
            r_in_byte <= i_in_ch.data_byte;
            r_in_start <= i_in_ch.frame_start;
        end
    end

    emfp_frame_eval u_eval (
        .i_frame      (r_frame),
        .i_check_byte (r_in_byte),
        .i_sum        (r_sum),
        .i_held       (r_held),
        .o_status     (n_status),
        .o_held       (n_held)
    );

    // Byte position, running sum and held registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= POS_IDLE;
            r_sum <= '0;
            r_held <= '0;
        end else if (r_in_valid && advance) begin
            if (r_in_start) begin
                r_pos <= POS_W'(1);
                r_sum <= '0;
            end else if (r_pos < POS_IDLE) begin
                if (r_pos >= POS_W'(SUM_FIRST) && r_pos <= POS_W'(SUM_LAST)) begin
                    r_sum <= r_sum + r_in_byte;
                end
                if (finish) begin
                    r_pos <= POS_IDLE;
                    r_held <= n_held;
                end else begin
                    r_pos <= r_pos + POS_W'(1);
                end
            end
        end
    end

    // Frame bytes are kept where they land; byte 0 and the checksum are never needed.
    always_ff @(posedge i_clk) begin
        if (r_in_valid && advance && !r_in_start && r_pos < POS_W'(CHECK_POS)) begin
            r_frame[r_pos] <= r_in_byte;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (finish) begin
            r_out_valid <= 1'b1;
        end else if (o_out_ch.ready) begin
            r_out_valid <= 1'b0;
        end
        if (finish) begin
            r_out_status <= n_status;
            r_out_held <= n_held;
        end
    end

    assign o_out_ch.valid = r_out_valid;
    assign o_out_ch.status = r_out_status;
    assign o_out_ch.voltage_param = r_out_held.param[0];
    assign o_out_ch.voltage_value = r_out_held.data[0];
    assign o_out_ch.current_param = r_out_held.param[1];
    assign o_out_ch.current_value = r_out_held.data[1];
    assign o_out_ch.power_param = r_out_held.param[2];
    assign o_out_ch.power_value = r_out_held.data[2];
    assign o_out_ch.pulse_register = r_out_held.pulse;
    assign o_out_ch.pulse_wrap_count = 32'(r_out_held.wrap_cnt);
    assign o_out_ch.flagged_frame_count = 32'(r_out_held.flag_cnt);

endmodule

/* rtl/core/emfp_checker.sv */
`include "assert_macros.svh"

// Port-level checks on the frame parser.
module emfp_checker
    import emfp_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_in_start,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  i_status,
    input logic [31:0] i_flag_cnt
);

    // Flagged count carried by the most recent result that was transferred.
    logic [31:0] r_last_flag_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_flag_cnt <= '0;
        end else if (i_out_valid && i_out_ready) begin
            r_last_flag_cnt <= i_flag_cnt;
        end
    end

    // No result is offered in the cycle after reset.
    `ASSERT_CLKD_ALWAYS(a_no_result_after_reset, i_clk, !i_rst_n |=> !i_out_valid)

    // A result that is not taken holds its status.
    `ASSERT_CLKD(a_status_held, i_clk, i_rst_n,
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_status))

    // The status carries only the three defined codes.
    `ASSERT_CLKD(a_status_code, i_clk, i_rst_n,
        i_out_valid |-> (i_status == ST_OK || i_status == ST_BAD_HEADER ||
                         i_status == ST_BAD_SUM))

    // A frame start needs at least 23 more transfers before a result, so none follows at once.
    `ASSERT_CLKD(a_start_no_quick_result, i_clk, i_rst_n,
        i_in_valid && i_in_ready && i_in_start && !i_out_valid |=> ##1 !$rose(i_out_valid))

    // A failed frame leaves the flagged count as the previous result showed it.
    `ASSERT_CLKD(a_error_keeps_flags, i_clk, i_rst_n,
        i_out_valid && i_status != ST_OK |-> i_flag_cnt == r_last_flag_cnt)

endmodule

bind energy_meter_frame_parser_core emfp_checker u_emfp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_ch.valid),
    .i_in_ready  (i_in_ch.ready),
    .i_in_start  (i_in_ch.frame_start),
    .i_out_valid (o_out_ch.valid),
    .i_out_ready (o_out_ch.ready),
    .i_status    (o_out_ch.status),
    .i_flag_cnt  (o_out_ch.flagged_frame_count)
);

/* dv/tb.sv */
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import emfp_pkg::*;

    typedef t_byte t_frame [FRAME_LEN];

    // One reading as the parser should report it.
    typedef struct {
        t_status status;
        t_held   held;
    } t_meter_reading;

    logic i_clk;
    logic i_rst_n;

    emfp_in_if  in_ch ();
    emfp_out_if out_ch ();

    energy_meter_frame_parser_core dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in_ch  (in_ch),
        .o_out_ch (out_ch)
    );

    // Predictor state: parse position, running sum, captured bytes and held registers.
    int unsigned    parse_pos;
    t_byte          running_sum;
    t_byte          frame_copy [FRAME_LEN];
    t_held          meter_state;
    t_meter_reading expected_readings [$];

    int unsigned bytes_sent;
    int unsigned mismatch_count;
    bit          idle_enable;

    // Clock with a 10 ns period.
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Work out the reading, if any, that one accepted byte causes.
    task automatic parse_byte(input t_byte b, input bit start);
        t_meter_reading r;
        t_byte          st;
        logic [15:0]    pulse;
        if (start) begin
            frame_copy[0] = b;
            running_sum = '0;
            parse_pos = 1;
            return;
        end
        if (parse_pos >= FRAME_LEN) begin
            return;
        end
        frame_copy[parse_pos] = b;
        if (parse_pos >= SUM_FIRST && parse_pos <= SUM_LAST) begin
            running_sum += b;
        end
        if (parse_pos != CHECK_POS) begin
            parse_pos++;
            return;
        end
        parse_pos = FRAME_LEN;
        // A bad header takes precedence over a bad checksum; errors leave state alone.
        if (frame_copy[1] != HEADER_BYTE) begin
            r.status = ST_BAD_HEADER;
        end else if (running_sum != frame_copy[CHECK_POS]) begin
            r.status = ST_BAD_SUM;
        end else begin
            r.status = ST_OK;
            st = frame_copy[STATUS_POS];
            for (int k = 0; k < 3; k++) begin
                meter_state.param[k] = {frame_copy[2 + 6 * k], frame_copy[3 + 6 * k],
                                        frame_copy[4 + 6 * k]};
                if (st[6 - k]) begin
                    meter_state.data[k] = {frame_copy[5 + 6 * k], frame_copy[6 + 6 * k],
                                           frame_copy[7 + 6 * k]};
                end
            end
            pulse = {frame_copy[PULSE_HI_POS], frame_copy[PULSE_LO_POS]};
            if (st[7]) begin
                meter_state.flag_cnt++;
            end
            if (meter_state.pulse > pulse) begin
                meter_state.wrap_cnt++;
            end
            meter_state.pulse = pulse;
        end
        r.held = meter_state;
        expected_readings.push_back(r);
    endtask

    // Send one byte; valid stays high after the transfer so that back-to-back bytes flow.
    task automatic send_byte(input t_byte b, input bit start);
        int unsigned gap;
        gap = idle_enable ? $urandom_range(0, 4) : 0;
        repeat (gap) begin
            @(negedge i_clk);
            in_ch.valid <= 1'b0;
        end
        @(negedge i_clk);
        in_ch.valid <= 1'b1;
        in_ch.data_byte <= b;
        in_ch.frame_start <= start;
        do @(posedge i_clk); while (!in_ch.ready);
        parse_byte(b, start);
        bytes_sent++;
    endtask

    // Send the first count bytes of a frame; byte 0 carries the start marker.
    task automatic send_frame(input t_frame f, input int unsigned count);
        for (int unsigned i = 0; i < count; i++) begin
            send_byte(f[i], i == 0);
        end
    endtask

    // Hold the input quiet until every outstanding reading has been taken.
    task automatic wait_readings_drained();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (expected_readings.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    function automatic t_frame seal_frame(input t_frame f);
        t_byte sum;
        sum = '0;
        for (int unsigned i = SUM_FIRST; i <= SUM_LAST; i++) begin
            sum += f[i];
        end
        f[CHECK_POS] = sum;
        return f;
    endfunction

    // Well-formed frame with random content; the pulse register sometimes sits at an extreme.
    function automatic t_frame make_good_frame();
        t_frame f;
        for (int unsigned i = 0; i < FRAME_LEN; i++) begin
            f[i] = t_byte'($urandom_range(0, 255));
        end
        f[1] = HEADER_BYTE;
        case ($urandom_range(0, 9))
            0: begin
                f[PULSE_HI_POS] = 8'h00;
                f[PULSE_LO_POS] = 8'h00;
            end
            1: begin
                f[PULSE_HI_POS] = 8'hFF;
                f[PULSE_LO_POS] = 8'hFF;
            end
            default: ;
        endcase
        return seal_frame(f);
    endfunction

    function automatic void check_field(input string name, input logic [31:0] exp_v,
                                        input logic [31:0] act_v);
        if (act_v !== exp_v) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
                $display("%0t: %s expected %h, got %h", $realtime, name, exp_v, act_v);
            end
        end
    endfunction

    // Compare one taken reading with the oldest expectation.
    function automatic void check_reading();
        t_meter_reading r;
        if (expected_readings.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
                $display("%0t: reading with status %0d arrived unexpectedly", $realtime,
                         out_ch.status);
            end
            return;
        end
        r = expected_readings.pop_front();
        check_field("status", 32'(r.status), 32'(out_ch.status));
        check_field("voltage_param", 32'(r.held.param[0]), 32'(out_ch.voltage_param));
        check_field("voltage_value", 32'(r.held.data[0]), 32'(out_ch.voltage_value));
        check_field("current_param", 32'(r.held.param[1]), 32'(out_ch.current_param));
        check_field("current_value", 32'(r.held.data[1]), 32'(out_ch.current_value));
        check_field("power_param", 32'(r.held.param[2]), 32'(out_ch.power_param));
        check_field("power_value", 32'(r.held.data[2]), 32'(out_ch.power_value));
        check_field("pulse_register", 32'(r.held.pulse), 32'(out_ch.pulse_register));
        check_field("pulse_wrap_count", 32'(r.held.wrap_cnt), out_ch.pulse_wrap_count);
        check_field("flagged_frame_count", 32'(r.held.flag_cnt),
                    out_ch.flagged_frame_count);
    endfunction

    // Reading sink: stalls a random number of cycles once a reading is on offer.
    initial begin : reading_sink
        int unsigned stall;
        out_ch.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = idle_enable ? $urandom_range(0, 4) : 0;
            if (stall != 0) begin
                @(negedge i_clk);
                out_ch.ready <= 1'b0;
                do @(posedge i_clk); while (!out_ch.valid);
                repeat (stall - 1) @(negedge i_clk);
            end
            @(negedge i_clk);
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
            check_reading();
        end
    end

    // Bytes outside a frame are dropped without a reading.
    task automatic test_idle_bytes();
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(HEADER_BYTE, 1'b0);
    endtask

    // Extreme field values, each data-enable bit on its own, pulse wrap and flag count.
    task automatic test_good_frames();
        t_frame      f;
        t_byte       status_bytes [4];
        status_bytes = '{8'h40, 8'h20, 8'h10, 8'h80};
        foreach (f[i]) f[i] = 8'hFF;
        f[1] = HEADER_BYTE;
        send_frame(seal_frame(f), FRAME_LEN);
        foreach (f[i]) f[i] = 8'h00;
        f[1] = HEADER_BYTE;
        send_frame(seal_frame(f), FRAME_LEN);
        foreach (status_bytes[j]) begin
            f = make_good_frame();
            f[STATUS_POS] = status_bytes[j];
            send_frame(seal_frame(f), FRAME_LEN);
        end
    endtask

    // A bad header is reported as such even when the checksum fails too.
    task automatic test_bad_header();
        t_frame f;
        f = make_good_frame();
        f[1] = 8'hA5;
        send_frame(seal_frame(f), FRAME_LEN);
        f = make_good_frame();
        f[1] = 8'h00;
        f[CHECK_POS] = f[CHECK_POS] + 8'd1;
        send_frame(f, FRAME_LEN);
    endtask

    task automatic test_bad_checksum();
        t_frame f;
        f = make_good_frame();
        f[CHECK_POS] = f[CHECK_POS] ^ 8'h80;
        send_frame(f, FRAME_LEN);
    endtask

    // A start marker drops the partial frame, even one byte short of the end.
    task automatic test_restart_mid_frame();
        send_frame(make_good_frame(), 9);
        send_frame(make_good_frame(), CHECK_POS);
        send_frame(make_good_frame(), FRAME_LEN);
        wait_readings_drained();
    endtask

    // Mostly well-formed frames with random content, plus broken frames and noise.
    task automatic test_random_frames();
        t_frame      f;
        int unsigned kind;
        while (bytes_sent < 750) begin
            idle_enable = ($urandom_range(0, 3) != 0);
            kind = $urandom_range(0, 99);
            f = make_good_frame();
            if (kind < 65) begin
                send_frame(f, FRAME_LEN);
            end else if (kind < 75) begin
                do f[1] = t_byte'($urandom_range(0, 255)); while (f[1] == HEADER_BYTE);
                if ($urandom_range(0, 1)) begin
                    f = seal_frame(f);
                end
                send_frame(f, FRAME_LEN);
            end else if (kind < 85) begin
                f[CHECK_POS] = f[CHECK_POS] + t_byte'($urandom_range(1, 255));
                send_frame(f, FRAME_LEN);
            end else if (kind < 92) begin
                send_frame(f, $urandom_range(1, CHECK_POS));
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    send_byte(t_byte'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                end
            end
            if ($urandom_range(0, 19) == 0) begin
                wait_readings_drained();
            end
        end
    endtask

    // Stimulus: reset, directed tests, then random frames.
    initial begin : stimulus
        i_rst_n = 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.data_byte <= '0;
        in_ch.frame_start <= 1'b0;
        parse_pos = FRAME_LEN;
        running_sum = '0;
        meter_state = '0;
        bytes_sent = 0;
        mismatch_count = 0;
        idle_enable = 1'b1;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_idle_bytes();
        test_good_frames();
        test_bad_header();
        test_bad_checksum();
        test_restart_mid_frame();
        test_random_frames();

        wait_readings_drained();
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin : watchdog
        #2_000_000;
        $display("tb: done, errors");
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/emfp_pkg.sv
rtl/core/emfp_if.sv
rtl/core/emfp_frame_eval.sv
rtl/core/energy_meter_frame_parser_core.sv
rtl/core/emfp_checker.sv
dv/tb.sv
